// ===== src/sha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// shared sizes, transaction kind codes and control structs of the slot
// handle allocator
// ----------------------------------------------------------------------------
package sha_pkg;

   // table capacity and reference width
   localparam int SLOTS      = 1024;
   localparam int REF_BITS   = 48;
   localparam int SLOT_BITS  = $clog2(SLOTS);
   localparam int COUNT_BITS = SLOT_BITS + 1;

   localparam logic [COUNT_BITS-1:0] SLOTS_COUNT = COUNT_BITS'(SLOTS);

   // transaction kinds
   localparam logic [1:0] KIND_REGISTER   = 2'd0;
   localparam logic [1:0] KIND_UNREGISTER = 2'd1;
   localparam logic [1:0] KIND_LOOKUP     = 2'd2;

   // free stack control from the sequencer
   typedef struct packed {
      logic                 rd_en;
      logic                 pop;
      logic                 push;
      logic [SLOT_BITS-1:0] push_slot;
   } sha_stack_ctl_type;

   // free stack status back to the sequencer
   typedef struct packed {
      logic [COUNT_BITS-1:0] count;
      logic [SLOT_BITS-1:0]  top_slot;
   } sha_stack_sts_type;

endpackage

// ===== src/sha_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha request and response channels
// valid/ready channels; a transaction moves when both are high at a clock edge
// ----------------------------------------------------------------------------
interface sha_req_if import sha_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           kind;
   logic [SLOT_BITS-1:0] slot_number;
   logic [REF_BITS-1:0]  object_ref;

   modport source (output valid, kind, slot_number, object_ref, input ready);
   modport sink   (input valid, kind, slot_number, object_ref, output ready);
endinterface

interface sha_rsp_if import sha_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [SLOT_BITS-1:0] result_slot;
   logic                 ok;
   logic [REF_BITS-1:0]  stored_ref;

   modport source (output valid, result_slot, ok, stored_ref, input ready);
   modport sink   (input valid, result_slot, ok, stored_ref, output ready);
endinterface

// ===== src/sha_entry_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_entry_ram
// entry table: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module sha_entry_ram import sha_pkg::*; (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [SLOT_BITS-1:0] rd_addr,
   output logic [REF_BITS-1:0]  rd_data,
   input  logic                 wr_en,
   input  logic [SLOT_BITS-1:0] wr_addr,
   input  logic [REF_BITS-1:0]  wr_data
);

   logic [REF_BITS-1:0] mem [SLOTS];
   logic [REF_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/sha_free_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_free_stack
// lifo of freed slots in a memory, with the fill count and a registered
// read of the top entry
// ----------------------------------------------------------------------------
module sha_free_stack import sha_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  sha_stack_ctl_type ctl,
   output sha_stack_sts_type sts
);

   logic [SLOT_BITS-1:0]  mem [SLOTS];
   logic [SLOT_BITS-1:0]  top_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic [COUNT_BITS-1:0] top_index;

   assign top_index = count_ff - COUNT_BITS'(1);

   // fill count
   always_comb begin
      count_in = count_ff;
      if (ctl.pop) begin
         count_in = count_ff - COUNT_BITS'(1);
      end else if (ctl.push) begin
         count_in = count_ff + COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // push writes just above the top; only issued while count is below capacity
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[count_ff[SLOT_BITS-1:0]] <= ctl.push_slot;
      end
   end

   // top entry read, meaningful only when count is nonzero
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         top_ff <= mem[top_index[SLOT_BITS-1:0]];
      end
   end

   assign sts.count    = count_ff;
   assign sts.top_slot = top_ff;

endmodule

// ===== src/slot_handle_allocator_unit.sv =====
`timescale 1ns / 1ps
// a transaction leaves the pending stage once the output register is free or being read
// a new request is taken only after the previous one leaves the pending stage, set by the
//   memory read then write-back of the entry table and free stack for each transaction
// a new request is taken while the previous response still waits in the output register
// reset: synchronous, clears the free count, high-water mark and all valid flags;
//   table and stack memories are not cleared
// ----------------------------------------------------------------------------
// slot_handle_allocator_unit
// handle table with a lifo free list: register, unregister and lookup
// ----------------------------------------------------------------------------
module slot_handle_allocator_unit import sha_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   sha_req_if.sink   req_bus,
   sha_rsp_if.source rsp_bus
);

   // pending transaction, memories already read
   logic                  pend_valid_ff;
   logic                  pend_valid_in;
   logic [1:0]            kind_ff;
   logic [SLOT_BITS-1:0]  slot_ff;
   logic [REF_BITS-1:0]   obj_ff;

   logic [COUNT_BITS-1:0] high_water_ff;
   logic [COUNT_BITS-1:0] high_water_in;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [SLOT_BITS-1:0]  rsp_slot_ff;
   logic                  rsp_ok_ff;
   logic [REF_BITS-1:0]   rsp_ref_ff;

   logic                  accept;
   logic                  finish;

   sha_stack_ctl_type     stack_ctl;
   sha_stack_sts_type     stack_sts;

   logic [REF_BITS-1:0]   entry_rd_data;
   logic                  entry_wr_en;
   logic [SLOT_BITS-1:0]  entry_wr_addr;
   logic [REF_BITS-1:0]  entry_wr_data;

   logic                  in_range;
   logic [SLOT_BITS-1:0]  res_slot;
   logic                  res_ok;
   logic [REF_BITS-1:0]   res_ref;

   // handshake
   assign req_bus.ready = !pend_valid_ff;
   assign accept        = req_bus.valid && !pend_valid_ff;
   assign finish        = pend_valid_ff && (!rsp_valid_ff || rsp_bus.ready);

   // memories
   sha_entry_ram u_entry_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (req_bus.slot_number),
      .rd_data (entry_rd_data),
      .wr_en   (entry_wr_en),
      .wr_addr (entry_wr_addr),
      .wr_data (entry_wr_data)
   );

   sha_free_stack u_free_stack (
      .clock (clock),
      .reset (reset),
      .ctl   (stack_ctl),
      .sts   (stack_sts)
   );

   // decode the pending transaction against current state
   assign in_range = {1'b0, slot_ff} < high_water_ff;

   always_comb begin
      res_slot           = slot_ff;
      res_ok             = 1'b0;
      res_ref            = '0;
      entry_wr_en        = 1'b0;
      entry_wr_addr      = slot_ff;
      entry_wr_data      = '0;
      high_water_in      = high_water_ff;
      stack_ctl.rd_en    = accept;
      stack_ctl.pop      = 1'b0;
      stack_ctl.push     = 1'b0;
      stack_ctl.push_slot = slot_ff;
      case (kind_ff)
         KIND_REGISTER: begin
            entry_wr_data = obj_ff;
            if (stack_sts.count != '0) begin
               // reuse the most recently freed slot
               stack_ctl.pop = finish;
               entry_wr_en   = finish;
               entry_wr_addr = stack_sts.top_slot;
               res_slot      = stack_sts.top_slot;
               res_ok        = 1'b1;
            end else if (high_water_ff < SLOTS_COUNT) begin
               // take the next never-used slot
               entry_wr_en   = finish;
               entry_wr_addr = high_water_ff[SLOT_BITS-1:0];
               res_slot      = high_water_ff[SLOT_BITS-1:0];
               res_ok        = 1'b1;
               if (finish) begin
                  high_water_in = high_water_ff + COUNT_BITS'(1);
               end
            end else begin
               // table full
               res_slot = '0;
            end
         end
         KIND_UNREGISTER: begin
            if (in_range) begin
               entry_wr_en = finish;
               if (stack_sts.count < SLOTS_COUNT) begin
                  stack_ctl.push = finish;
                  res_ok         = 1'b1;
               end
            end
         end
         KIND_LOOKUP: begin
            if (in_range) begin
               res_ref = entry_rd_data;
               res_ok  = 1'b1;
            end
         end
         default: begin
            res_ok = 1'b0;
         end
      endcase
   end

   // pending stage and output register valid flags
   assign pend_valid_in = accept || (pend_valid_ff && !finish);
   assign rsp_valid_in  = finish || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         high_water_ff <= '0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         high_water_ff <= high_water_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_bus.kind;
         slot_ff <= req_bus.slot_number;
         obj_ff  <= req_bus.object_ref;
      end
      if (finish) begin
         rsp_slot_ff <= res_slot;
         rsp_ok_ff   <= res_ok;
         rsp_ref_ff  <= res_ref;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.result_slot = rsp_slot_ff;
   assign rsp_bus.ok          = rsp_ok_ff;
   assign rsp_bus.stored_ref  = rsp_ref_ff;

endmodule

// ===== src/sha_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_checker
// port-level checks of the slot handle allocator, bound to the top level
// ----------------------------------------------------------------------------
module sha_checker import sha_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [SLOT_BITS-1:0] rsp_result_slot,
   input logic                 rsp_ok,
   input logic [REF_BITS-1:0]  rsp_stored_ref
);

   // a failed transaction never reports a reference
   a_fail_null_ref: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_stored_ref == '0)
      else $error("failed response carries a reference");

   // an accepted request blocks the next request right after it
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is pending");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_slot)
         && $stable(rsp_ok) && $stable(rsp_stored_ref))
      else $error("stalled response changed");

endmodule

bind slot_handle_allocator_unit sha_checker u_sha_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_result_slot (rsp_bus.result_slot),
   .rsp_ok          (rsp_bus.ok),
   .rsp_stored_ref  (rsp_bus.stored_ref)
);
